// File: hw/rtl/aabbcr_pkg.sv
// Shared types and constants for the AABB collision resolver.
package aabbcr_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_REG_W = 16;

	// register index (paddr[3:2])
	localparam logic [1:0] REG_WARP_MARGIN = 2'd0;
	localparam logic [1:0] REG_FLOOR_SNAP_BAND = 2'd1;
	localparam logic [1:0] REG_FRAME_TIME = 2'd2;

	localparam logic [CFG_REG_W-1:0] WARP_MARGIN_RST = 16'd512;
	localparam logic [CFG_REG_W-1:0] FLOOR_SNAP_BAND_RST = 16'd2560;
	localparam logic [CFG_REG_W-1:0] FRAME_TIME_RST = 16'd1092;

	typedef enum logic [2:0] {
		SIDE_NONE = 3'd0,
		SIDE_LEFT = 3'd1,
		SIDE_RIGHT = 3'd2,
		SIDE_TOP = 3'd3,
		SIDE_BOTTOM = 3'd4
	} side_t;

	typedef struct packed {
		logic [CFG_REG_W-1:0] warp_margin;
		logic [CFG_REG_W-1:0] floor_snap_band;
		logic [CFG_REG_W-1:0] frame_time;
	} cfg_t;

endpackage

// File: hw/rtl/aabbcr_cfg.sv
// APB register file holding the resolver configuration.
module aabbcr_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [aabbcr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [aabbcr_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [aabbcr_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                 pready,
	output aabbcr_pkg::cfg_t                     cfg
);
	import aabbcr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warp_margin <= WARP_MARGIN_RST;
			cfg_q.floor_snap_band <= FLOOR_SNAP_BAND_RST;
			cfg_q.frame_time <= FRAME_TIME_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WARP_MARGIN: cfg_q.warp_margin <= pwdata[CFG_REG_W-1:0];
				REG_FLOOR_SNAP_BAND: cfg_q.floor_snap_band <= pwdata[CFG_REG_W-1:0];
				REG_FRAME_TIME: cfg_q.frame_time <= pwdata[CFG_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WARP_MARGIN: prdata = CFG_DATA_W'(cfg_q.warp_margin);
			REG_FLOOR_SNAP_BAND: prdata = CFG_DATA_W'(cfg_q.floor_snap_band);
			REG_FRAME_TIME: prdata = CFG_DATA_W'(cfg_q.frame_time);
			default: prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/aabbcr_resolve.sv
// Single-block collision response: overlap test, side pick, fixes, push-out.
module aabbcr_resolve #(
	parameter int COORD_BITS = aabbcr_pkg::COORD_BITS_DEF
) (
	input  aabbcr_pkg::cfg_t                cfg,
	input  logic signed [COORD_BITS-1:0]    body_x,
	input  logic signed [COORD_BITS-1:0]    body_y,
	input  logic        [COORD_BITS-2:0]    body_w,
	input  logic        [COORD_BITS-2:0]    body_h,
	input  logic signed [COORD_BITS-1:0]    body_vx,
	input  logic signed [COORD_BITS-1:0]    body_vy,
	input  logic        [COORD_BITS-2:0]    body_travel,
	input  logic signed [COORD_BITS-1:0]    blk_x,
	input  logic signed [COORD_BITS-1:0]    blk_y,
	input  logic        [COORD_BITS-2:0]    blk_w,
	input  logic        [COORD_BITS-2:0]    blk_h,
	output logic signed [COORD_BITS-1:0]    new_x,
	output logic signed [COORD_BITS-1:0]    new_y,
	output logic signed [COORD_BITS-1:0]    new_vx,
	output logic signed [COORD_BITS-1:0]    new_vy,
	output aabbcr_pkg::side_t               side
);
	import aabbcr_pkg::*;

	// doubled centres need two extra bits, their difference one more
	localparam int W = COORD_BITS + 3;

	logic signed [W-1:0] px, py, sx, sy, bx, by, bw, bh;
	logic signed [W-1:0] d2x, d2y, absx, absy, ox, oy;
	logic signed [W-1:0] limit, foot, snap_lim, depth, push_x, push_y;
	logic gx, gy, overlap, vy_neg;
	side_t side_h, side_v, pick;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [W-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v[W-1:COORD_BITS-1] == {(W-COORD_BITS+1){v[W-1]}})
			r = v[COORD_BITS-1:0];
		else
			r = {v[W-1], {(COORD_BITS-1){~v[W-1]}}};
		return r;
	endfunction

	assign px = W'(body_x);
	assign py = W'(body_y);
	assign sx = W'(body_w);
	assign sy = W'(body_h);
	assign bx = W'(blk_x);
	assign by = W'(blk_y);
	assign bw = W'(blk_w);
	assign bh = W'(blk_h);

	assign overlap = (px < bx + bw) && (px + sx > bx) && (py < by + bh) && (py + sy > by);

	assign d2x = ((px <<< 1) + sx) - ((bx <<< 1) + bw);
	assign d2y = ((py <<< 1) + sy) - ((by <<< 1) + bh);
	assign absx = d2x[W-1] ? -d2x : d2x;
	assign absy = d2y[W-1] ? -d2y : d2y;
	// sum of sizes and doubled centre gap share parity, so the halving is exact
	assign ox = ((sx + bw) - absx) >>> 1;
	assign oy = ((sy + bh) - absy) >>> 1;
	assign gx = !d2x[W-1] && (d2x != '0);
	assign gy = !d2y[W-1] && (d2y != '0);

	assign limit = W'(body_travel) + W'(cfg.warp_margin);
	assign foot = py + sy;
	assign snap_lim = by + W'(cfg.floor_snap_band);
	assign vy_neg = body_vy[COORD_BITS-1];

	assign side_h = gx ? SIDE_LEFT : SIDE_RIGHT;
	assign side_v = gy ? SIDE_TOP : SIDE_BOTTOM;

	always_comb begin
		if (ox < oy) begin
			pick = side_h;
			depth = ox;
		end else begin
			pick = side_v;
			depth = oy;
		end
		if (pick == SIDE_LEFT || pick == SIDE_RIGHT) begin
			if (depth > limit) begin
				// push too large for one frame of travel: treat as vertical
				pick = side_v;
				depth = oy;
			end else if (foot >= by && foot <= snap_lim && !vy_neg) begin
				pick = SIDE_BOTTOM;
				depth = foot - by;
			end
		end
		if (pick == SIDE_BOTTOM && vy_neg) begin
			pick = side_h;
			depth = ox;
		end
		if (!overlap || depth[W-1] || depth == '0)
			pick = SIDE_NONE;
	end

	assign side = pick;
	assign push_x = (pick == SIDE_LEFT) ? px + depth : px - depth;
	assign push_y = (pick == SIDE_TOP) ? py + depth : py - depth;

	always_comb begin
		new_x = body_x;
		new_y = body_y;
		new_vx = body_vx;
		new_vy = body_vy;
		case (pick)
			SIDE_LEFT: begin
				new_x = sat_coord(push_x);
				if (body_vx[COORD_BITS-1])
					new_vx = '0;
			end
			SIDE_RIGHT: begin
				new_x = sat_coord(push_x);
				if (!body_vx[COORD_BITS-1] && body_vx != '0)
					new_vx = '0;
			end
			SIDE_TOP: begin
				new_y = sat_coord(push_y);
				new_vy = '0;
			end
			SIDE_BOTTOM: begin
				new_y = sat_coord(push_y);
				if (!vy_neg && body_vy != '0)
					new_vy = '0;
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/aabb_collision_resolver_core.sv
// AABB collision resolver top level: input register, body state, result register.
// Flow: an accepted input beat is held in the stage-1 register, resolved, and presented
// from the result register.
// Throughput: one item per cycle unless m_tready stalls the result; the body state is
// updated by the stage-1 item in the same cycle, so each block sees the previous block's push.
// Reset (arst_n low) clears body state, flags, ceiling rectangle and both
// pipeline stages, and loads the configuration registers with their defaults.
module aabb_collision_resolver_core #(
	parameter int COORD_BITS = aabbcr_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [aabbcr_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [aabbcr_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [aabbcr_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                      pready,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// rect_x, rect_y, rect_w, rect_h, speed_x, speed_y
	input  logic [((6*COORD_BITS+5)/8)*8-1:0]         s_tdata,
	// mode
	input  logic                                      s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// pos_x, pos_y, vel_x, vel_y, grounded, ceiling_hit, ceiling_x, ceiling_y,
	// ceiling_w, ceiling_h, push_side
	output logic [((8*COORD_BITS+10)/8)*8-1:0]        m_tdata
);
	import aabbcr_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int OUT_W = ((8*COORD_BITS+10)/8)*8;

	cfg_t cfg;

	logic accept_in, advance;
	logic signed [CB-1:0] in_speed_x;
	logic [CB-1:0] abs_speed_x;
	logic [CB+15:0] travel_prod;
	logic [CB-1:0] abs_body_vx;
	logic [CB+15:0] idle_prod;

	logic valid_s1, mode_s1;
	logic signed [CB-1:0] rect_x_s1, rect_y_s1, speed_x_s1, speed_y_s1;
	logic [CB-2:0] rect_w_s1, rect_h_s1, travel_s1;

	logic signed [CB-1:0] body_x_q, body_y_q, body_vx_q, body_vy_q;
	logic [CB-2:0] body_w_q, body_h_q, body_travel_q;
	logic grounded_q, ceil_hit_q;
	logic signed [CB-1:0] ceil_x_q, ceil_y_q;
	logic [CB-2:0] ceil_w_q, ceil_h_q;

	logic signed [CB-1:0] res_x, res_y, res_vx, res_vy;
	side_t res_side;

	logic signed [CB-1:0] nx_x, nx_y, nx_vx, nx_vy, nx_ceil_x, nx_ceil_y;
	logic [CB-2:0] nx_w, nx_h, nx_travel, nx_ceil_w, nx_ceil_h;
	logic nx_grounded, nx_ceil_hit;
	side_t nx_side;

	logic m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	aabbcr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || !m_valid_q || m_tready;
	assign accept_in = s_tvalid && s_tready;

	// per-frame horizontal travel of a body beat, precomputed ahead of stage 1
	assign in_speed_x = s_tdata[5*CB-3:4*CB-2];
	assign abs_speed_x = in_speed_x[CB-1] ? CB'(-in_speed_x) : CB'(in_speed_x);
	assign travel_prod = (CB+16)'(abs_speed_x) * (CB+16)'(cfg.frame_time);

	// travel of the held body, refreshed in idle cycles so a new frame_time takes effect
	assign abs_body_vx = body_vx_q[CB-1] ? CB'(-body_vx_q) : CB'(body_vx_q);
	assign idle_prod = (CB+16)'(abs_body_vx) * (CB+16)'(cfg.frame_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_s1 <= s_tuser;
			rect_x_s1 <= s_tdata[CB-1:0];
			rect_y_s1 <= s_tdata[2*CB-1:CB];
			rect_w_s1 <= s_tdata[3*CB-2:2*CB];
			rect_h_s1 <= s_tdata[4*CB-3:3*CB-1];
			speed_x_s1 <= in_speed_x;
			speed_y_s1 <= s_tdata[6*CB-3:5*CB-2];
			travel_s1 <= travel_prod[CB+14:16];
		end
	end

	aabbcr_resolve #(.COORD_BITS(COORD_BITS)) u_resolve (
		.cfg         (cfg),
		.body_x      (body_x_q),
		.body_y      (body_y_q),
		.body_w      (body_w_q),
		.body_h      (body_h_q),
		.body_vx     (body_vx_q),
		.body_vy     (body_vy_q),
		.body_travel (body_travel_q),
		.blk_x       (rect_x_s1),
		.blk_y       (rect_y_s1),
		.blk_w       (rect_w_s1),
		.blk_h       (rect_h_s1),
		.new_x       (res_x),
		.new_y       (res_y),
		.new_vx      (res_vx),
		.new_vy      (res_vy),
		.side        (res_side)
	);

	always_comb begin
		nx_ceil_x = ceil_x_q;
		nx_ceil_y = ceil_y_q;
		nx_ceil_w = ceil_w_q;
		nx_ceil_h = ceil_h_q;
		nx_w = body_w_q;
		nx_h = body_h_q;
		if (!mode_s1) begin
			nx_x = rect_x_s1;
			nx_y = rect_y_s1;
			nx_w = rect_w_s1;
			nx_h = rect_h_s1;
			nx_vx = speed_x_s1;
			nx_vy = speed_y_s1;
			nx_travel = travel_s1;
			nx_grounded = 1'b0;
			nx_ceil_hit = 1'b0;
			nx_side = SIDE_NONE;
		end else begin
			nx_x = res_x;
			nx_y = res_y;
			nx_vx = res_vx;
			nx_vy = res_vy;
			// vel_x only changes by being zeroed, and zero speed means zero travel
			nx_travel = (res_vx == '0) ? '0 : body_travel_q;
			nx_grounded = grounded_q || (res_side == SIDE_BOTTOM);
			nx_ceil_hit = ceil_hit_q || (res_side == SIDE_TOP);
			nx_side = res_side;
			if (res_side == SIDE_TOP) begin
				nx_ceil_x = rect_x_s1;
				nx_ceil_y = rect_y_s1;
				nx_ceil_w = rect_w_s1;
				nx_ceil_h = rect_h_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_x_q <= '0;
			body_y_q <= '0;
			body_w_q <= '0;
			body_h_q <= '0;
			body_vx_q <= '0;
			body_vy_q <= '0;
			body_travel_q <= '0;
			grounded_q <= 1'b0;
			ceil_hit_q <= 1'b0;
			ceil_x_q <= '0;
			ceil_y_q <= '0;
			ceil_w_q <= '0;
			ceil_h_q <= '0;
		end else if (advance) begin
			body_x_q <= nx_x;
			body_y_q <= nx_y;
			body_w_q <= nx_w;
			body_h_q <= nx_h;
			body_vx_q <= nx_vx;
			body_vy_q <= nx_vy;
			body_travel_q <= nx_travel;
			grounded_q <= nx_grounded;
			ceil_hit_q <= nx_ceil_hit;
			ceil_x_q <= nx_ceil_x;
			ceil_y_q <= nx_ceil_y;
			ceil_w_q <= nx_ceil_w;
			ceil_h_q <= nx_ceil_h;
		end else begin
			body_travel_q <= idle_prod[CB+14:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= OUT_W'({nx_side, nx_ceil_h, nx_ceil_w, nx_ceil_y, nx_ceil_x,
				nx_ceil_hit, nx_grounded, nx_vy, nx_vx, nx_y, nx_x});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

// File: hw/rtl/aabbcr_checker.sv
// Port-level checks for the AABB collision resolver, bound to the top level.
module aabbcr_checker #(
	parameter int COORD_BITS = aabbcr_pkg::COORD_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((8*COORD_BITS+10)/8)*8-1:0]   m_tdata
);
	import aabbcr_pkg::*;

	localparam int GND_BIT = 4*COORD_BITS;
	localparam int CEIL_BIT = 4*COORD_BITS + 1;
	localparam int SIDE_LO = 8*COORD_BITS;

	logic [2:0] side_out;
	assign side_out = m_tdata[SIDE_LO+2:SIDE_LO];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (side_out == SIDE_NONE || side_out == SIDE_LEFT ||
			side_out == SIDE_RIGHT || side_out == SIDE_TOP || side_out == SIDE_BOTTOM))
		else $error("push_side out of range");

	a_floor_sets_ground: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && side_out == SIDE_BOTTOM |-> m_tdata[GND_BIT])
		else $error("floor push without grounded flag");

	a_top_sets_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && side_out == SIDE_TOP |-> m_tdata[CEIL_BIT])
		else $error("ceiling push without ceiling flag");

endmodule

bind aabb_collision_resolver_core aabbcr_checker #(.COORD_BITS(COORD_BITS)) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/testbench.sv
// Self-checking testbench for the AABB collision resolver core.
`timescale 1ns / 100ps

module testbench;
	import aabbcr_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int IN_W = ((6*CB+5)/8)*8;
	localparam int OUT_W = ((8*CB+10)/8)*8;
	localparam int N_FLD = 11;

	typedef struct {
		bit mode;
		logic signed [CB-1:0] rx;
		logic signed [CB-1:0] ry;
		logic [CB-2:0] rw;
		logic [CB-2:0] rh;
		logic signed [CB-1:0] vx;
		logic signed [CB-1:0] vy;
	} collide_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;	// rect_x, rect_y, rect_w, rect_h, speed_x, speed_y
	logic s_tuser = 1'b0;		// mode
	logic m_tvalid;
	logic m_tready = 1'b0;
	// pos_x, pos_y, vel_x, vel_y, grounded, ceiling_hit, ceiling_x, ceiling_y,
	// ceiling_w, ceiling_h, push_side
	logic [OUT_W-1:0] m_tdata;

	aabb_collision_resolver_core #(.COORD_BITS(CB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// shadow of the registers
	longint cfg_warp_margin = WARP_MARGIN_RST;
	longint cfg_snap_band = FLOOR_SNAP_BAND_RST;
	longint cfg_frame_time = FRAME_TIME_RST;

	// tracked body
	longint body_x = 0, body_y = 0, body_w = 0, body_h = 0, body_vx = 0, body_vy = 0;
	bit on_floor = 0, ceil_hit = 0;
	longint ceil_rx = 0, ceil_ry = 0, ceil_rw = 0, ceil_rh = 0;

	collide_item_t pending_q[$];
	logic [OUT_W-1:0] body_state_q[$];

	collide_item_t drv_item, acc_item;
	logic [OUT_W-1:0] exp_beat, fmask, exp_f, act_f, pred_beat;
	logic [CFG_DATA_W-1:0] reg_val;

	int errors = 0;
	int items_in = 0;
	int loads_in = 0;
	int beats_seen = 0;
	int side_cnt[5] = '{0, 0, 0, 0, 0};
	int src_idle_pct = 13;
	int sink_idle_pct = 13;
	int hold_left = 0;
	bit hold_done = 0;

	string fld_name[N_FLD] = '{"pos_x", "pos_y", "vel_x", "vel_y", "grounded", "ceiling_hit",
		"ceiling_x", "ceiling_y", "ceiling_w", "ceiling_h", "push_side"};
	int fld_ofs[N_FLD] = '{0, 24, 48, 72, 96, 97, 98, 122, 146, 169, 192};
	int fld_w[N_FLD] = '{24, 24, 24, 24, 1, 1, 24, 24, 23, 23, 3};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp_coord(longint v);
		longint hi;
		hi = (longint'(1) <<< (CB-1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Applies one item to the tracked body and returns the expected result beat.
	function automatic logic [OUT_W-1:0] advance_body(collide_item_t it);
		longint bx, by, bw, bh, d2x, d2y, ox, oy, depth, limit, foot;
		bit gx, gy;
		side_t side;
		logic [OUT_W-1:0] r;
		bx = it.rx;
		by = it.ry;
		bw = it.rw;
		bh = it.rh;
		side = SIDE_NONE;
		if (!it.mode) begin
			body_x = bx;
			body_y = by;
			body_w = bw;
			body_h = bh;
			body_vx = it.vx;
			body_vy = it.vy;
			on_floor = 0;
			ceil_hit = 0;
		end else if (body_x < bx + bw && body_x + body_w > bx &&
				body_y < by + bh && body_y + body_h > by) begin
			// doubled centres keep the depths exact
			d2x = (2*body_x + body_w) - (2*bx + bw);
			d2y = (2*body_y + body_h) - (2*by + bh);
			gx = d2x > 0;
			gy = d2y > 0;
			ox = (body_w + bw - (d2x < 0 ? -d2x : d2x)) / 2;
			oy = (body_h + bh - (d2y < 0 ? -d2y : d2y)) / 2;
			if (ox < oy) begin
				depth = ox;
				side = gx ? SIDE_LEFT : SIDE_RIGHT;
			end else begin
				depth = oy;
				side = gy ? SIDE_TOP : SIDE_BOTTOM;
			end
			if (side == SIDE_LEFT || side == SIDE_RIGHT) begin
				limit = (((body_vx < 0 ? -body_vx : body_vx) * cfg_frame_time) >>> 16)
					+ cfg_warp_margin;
				if (depth > limit) begin
					depth = oy;
					side = gy ? SIDE_TOP : SIDE_BOTTOM;
				end else begin
					foot = body_y + body_h;
					if (foot >= by && foot <= by + cfg_snap_band && body_vy >= 0) begin
						side = SIDE_BOTTOM;
						depth = foot - by;
					end
				end
			end
			// rising body never lands on a floor
			if (side == SIDE_BOTTOM && body_vy < 0) begin
				depth = ox;
				side = gx ? SIDE_LEFT : SIDE_RIGHT;
			end
			if (depth <= 0)
				side = SIDE_NONE;
			case (side)
			SIDE_LEFT: begin
				body_x = clamp_coord(body_x + depth);
				if (body_vx < 0) body_vx = 0;
			end
			SIDE_RIGHT: begin
				body_x = clamp_coord(body_x - depth);
				if (body_vx > 0) body_vx = 0;
			end
			SIDE_TOP: begin
				body_y = clamp_coord(body_y + depth);
				body_vy = 0;
				ceil_hit = 1;
				ceil_rx = bx;
				ceil_ry = by;
				ceil_rw = bw;
				ceil_rh = bh;
			end
			SIDE_BOTTOM: begin
				body_y = clamp_coord(body_y - depth);
				on_floor = 1;
				if (body_vy > 0) body_vy = 0;
			end
			default: ;
			endcase
		end
		r = {side, ceil_rh[CB-2:0], ceil_rw[CB-2:0], ceil_ry[CB-1:0], ceil_rx[CB-1:0],
			ceil_hit, on_floor, body_vy[CB-1:0], body_vx[CB-1:0], body_y[CB-1:0],
			body_x[CB-1:0]};
		return r;
	endfunction

	function automatic void add_item(bit mode, int rx, int ry, int rw, int rh, int vx, int vy);
		collide_item_t it;
		it.mode = mode;
		it.rx = CB'(rx);
		it.ry = CB'(ry);
		it.rw = (CB-1)'(rw);
		it.rh = (CB-1)'(rh);
		it.vx = CB'(vx);
		it.vy = CB'(vy);
		pending_q.insert(pending_q.size(), it);
	endfunction

	function automatic int rand_speed();
		case ($urandom_range(3))
		0: return 0;
		1: return int'($urandom_range(2048)) - 1024;
		2: return int'($urandom_range(131072)) - 65536;
		default: return $urandom;
		endcase
	endfunction

	// Body loads followed by blocks placed around the body; a tenth is raw noise.
	task automatic queue_scenes(int n);
		int cnt, px, py, sw, sh, bw, bh, bx, by;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(99) < 10) begin
				add_item(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				cnt++;
			end else begin
				px = int'($urandom_range(32768)) - 16384;
				py = int'($urandom_range(32768)) - 16384;
				if ($urandom_range(19) == 0) px = $urandom;
				if ($urandom_range(19) == 0) py = $urandom;
				sw = $urandom_range(12288);
				sh = $urandom_range(12288);
				add_item(0, px, py, sw, sh, rand_speed(), rand_speed());
				cnt++;
				repeat ($urandom_range(1, 6)) begin
					bw = $urandom_range(16384);
					bh = $urandom_range(16384);
					bx = px - bw + int'($urandom_range(bw + sw + 512)) - 256;
					if ($urandom_range(2) == 0)
						by = py + sh - int'($urandom_range(3072));
					else
						by = py - bh + int'($urandom_range(bh + sh + 512)) - 256;
					add_item(1, bx, by, bw, bh, $urandom, $urandom);
					cnt++;
				end
			end
		end
	endtask

	task automatic apb_access(bit wr, logic [1:0] idx, logic [CFG_REG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= CFG_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_regs();
		apb_access(0, REG_WARP_MARGIN, 0);
		apb_access(0, REG_FLOOR_SNAP_BAND, 0);
		apb_access(0, REG_FRAME_TIME, 0);
	endtask

	// sampled mid-cycle so the driver and checker updates of this edge have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_q.size() != 0 || s_tvalid || body_state_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] wm, logic [15:0] fsb, logic [15:0] ft,
			int src_pct, int sink_pct, int n);
		apb_access(1, REG_WARP_MARGIN, wm);
		apb_access(1, REG_FLOOR_SNAP_BAND, fsb);
		apb_access(1, REG_FRAME_TIME, ft);
		check_regs();
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		queue_scenes(n);
		wait_drained();
	endtask

	// register shadow and read-back check
	always @(posedge clk) begin
		if (arst_n && psel && penable && pready) begin
			case (paddr[3:2])
			REG_WARP_MARGIN: reg_val = CFG_DATA_W'(cfg_warp_margin);
			REG_FLOOR_SNAP_BAND: reg_val = CFG_DATA_W'(cfg_snap_band);
			REG_FRAME_TIME: reg_val = CFG_DATA_W'(cfg_frame_time);
			default: reg_val = '0;
			endcase
			if (pwrite) begin
				case (paddr[3:2])
				REG_WARP_MARGIN: cfg_warp_margin = pwdata[CFG_REG_W-1:0];
				REG_FLOOR_SNAP_BAND: cfg_snap_band = pwdata[CFG_REG_W-1:0];
				REG_FRAME_TIME: cfg_frame_time = pwdata[CFG_REG_W-1:0];
				default: ;
				endcase
			end else if (prdata !== reg_val) begin
				errors++;
				$display("%0t: register %0d read: expected %h, actual %h",
					$time, paddr[3:2], reg_val, prdata);
			end
		end
	end

	// input driver
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drv_item = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_item.mode;
				s_tdata <= {drv_item.vy, drv_item.vx, drv_item.rh, drv_item.rw,
					drv_item.ry, drv_item.rx};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predict on every accepted input beat
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			acc_item.mode = s_tuser;
			acc_item.rx = s_tdata[23:0];
			acc_item.ry = s_tdata[47:24];
			acc_item.rw = s_tdata[70:48];
			acc_item.rh = s_tdata[93:71];
			acc_item.vx = s_tdata[117:94];
			acc_item.vy = s_tdata[141:118];
			pred_beat = advance_body(acc_item);
			body_state_q.insert(body_state_q.size(), pred_beat);
			items_in++;
			if (!acc_item.mode) loads_in++;
			if (pred_beat[194:192] < 5) side_cnt[pred_beat[194:192]]++;
		end
	end

	// result receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && beats_seen >= 150) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (body_state_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, m_tdata);
			end else begin
				exp_beat = body_state_q.pop_front();
				for (int f = 0; f < N_FLD; f++) begin
					fmask = '1;
					fmask = fmask >> (OUT_W - fld_w[f]);
					exp_f = (exp_beat >> fld_ofs[f]) & fmask;
					act_f = (m_tdata >> fld_ofs[f]) & fmask;
					if (act_f !== exp_f) begin
						errors++;
						$display("%0t: beat %0d %s: expected %h, actual %h", $time,
							beats_seen, fld_name[f], exp_f[23:0], act_f[23:0]);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_regs();
		// edges that touch, floor landing, ceiling hit
		add_item(0, 0, 0, 4096, 8192, 0, 256);
		add_item(1, 4096, 0, 4096, 8192, 0, 0);
		add_item(1, 0, 8192, 4096, 4096, 0, 0);
		add_item(1, -8192, 7936, 16384, 4096, 0, 0);
		add_item(0, 0, 0, 4096, 4096, 0, -512);
		add_item(1, -8192, -3840, 16384, 4096, 0, 0);
		// floor hit while rising turns sideways
		add_item(0, 0, 0, 4096, 4096, 256, -512);
		add_item(1, 0, 3840, 4096, 4096, 0, 0);
		// equal depths, then coincident centres
		add_item(0, 0, 0, 4096, 4096, 0, 0);
		add_item(1, 3840, 3840, 4096, 4096, 0, 0);
		add_item(0, 0, 0, 4096, 4096, 0, 0);
		add_item(1, 0, 0, 4096, 4096, 0, 0);
		add_item(0, 0, 0, 4096, 4096, 8388607, 0);
		add_item(1, 0, -2048, 4096, 8192, 0, 0);
		// horizontal push too deep for the travel
		add_item(0, 0, 0, 4096, 4096, 0, 0);
		add_item(1, 3072, -8192, 4096, 16384, 0, 0);
		// feet inside the snap band
		add_item(0, 0, 0, 4096, 4096, 0, 512);
		add_item(1, 3584, 2048, 4096, 16384, 0, 0);
		// position saturation both ways
		add_item(0, 8388600, 0, 200, 4096, 8388607, 0);
		add_item(1, 8388500, 0, 300, 4096, 0, 0);
		add_item(0, -8388608, 0, 200, 4096, -8388608, 0);
		add_item(1, -8388508, 0, 300, 4096, 0, 0);
		// field extremes, zero-size body
		add_item(0, -8388608, 8388607, 8388607, 8388607, 8388607, -8388608);
		add_item(1, 8388607, -8388608, 8388607, 0, -1, -1);
		add_item(0, 1000, 1000, 0, 0, 0, 0);
		add_item(1, 0, 0, 4096, 4096, -1, -1);
		queue_scenes(250);
		wait_drained();

		run_phase(16'h0000, 16'h0000, 16'h0000, 13, 13, 255);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 255);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 13, 13, 255);
		run_phase(16'd256, 16'd5120, 16'd2184, 13, 13, 255);
		repeat (10) @(posedge clk);

		$display("Ran %0d items (%0d body loads) over five register settings, %0d beats checked.",
			items_in, loads_in, beats_seen);
		$display("Pushes: none %0d, left %0d, right %0d, top %0d, bottom %0d.",
			side_cnt[0], side_cnt[1], side_cnt[2], side_cnt[3], side_cnt[4]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d beats still expected.", body_state_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/aabbcr_pkg.sv
hw/rtl/aabbcr_cfg.sv
hw/rtl/aabbcr_resolve.sv
hw/rtl/aabb_collision_resolver_core.sv
hw/rtl/aabbcr_checker.sv
sim/testbench.sv
